// ----- hw/rtl/signed_distance_field_radial_defines.svh -----
// Assertion macros used by the design file signed_distance_field_radial.sv.
`ifndef SIGNED_DISTANCE_FIELD_RADIAL_DEFINES_SVH
`define SIGNED_DISTANCE_FIELD_RADIAL_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SDF_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define SDF_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- hw/rtl/sdf_pkg.sv -----
package sdf_pkg;

    localparam int MAP_SIDE     = 1024;
    localparam int RADIUS_LIMIT = 64;
    localparam int CW           = $clog2(MAP_SIDE);
    localparam int RW           = $clog2(RADIUS_LIMIT + 1);
    localparam int D2W          = 2 * RW + 1;
    localparam int SW           = D2W + 16;
    localparam int ADDR_W       = 4;

    localparam logic [ADDR_W-1:0] REG_WIDTH  = 4'd0;
    localparam logic [ADDR_W-1:0] REG_HEIGHT = 4'd4;
    localparam logic [ADDR_W-1:0] REG_RADIUS = 4'd8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [31:0] HALF_Q = 32'd32768;
    localparam logic [31:0] MID_Q  = 32'd8355840;
    localparam logic [31:0] TOP_Q  = 32'd16711680;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        logic          pixel_bit;
    } sdf_in_t;

    typedef struct packed {
        logic [7:0]  sdf_value;
        logic [12:0] nearest_sq_distance;
        logic        bad_point;
    } sdf_out_t;

endpackage

// ----- hw/rtl/sdf_stream_if.sv -----
interface sdf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/signed_distance_field_radial.sv -----
// Bitmap distance sampler. A pixel write is a read-modify-write of one 32-bit
// word through the states S_WREAD and S_WWRITE. A query fetches the centre
// pixel through S_CREAD and S_CWAIT, then reads the bitmap one pixel per cycle
// within a ring from a single-port synchronous memory, walking square rings of
// radius 1 up to the configured search radius around the sample point, with
// S_PWAIT between rings. The square root and scaling in sdf_math then run
// before the result item is offered, and the state S_OUT passes before the
// next item is taken. Queries outside the map return at once with bad_point
// set. After reset the bitmap is cleared by a pass over its 32768 words, one
// 32-bit word a cycle, during which no item is taken; register writes are
// accepted throughout.
`include "signed_distance_field_radial_defines.svh"
module signed_distance_field_radial
    import sdf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    sdf_stream_if.sink        in_ch,
    sdf_stream_if.source      out_ch
);

    localparam int WB    = 5;
    localparam int WORDS = MAP_SIDE * MAP_SIDE / 32;
    localparam int AW    = $clog2(WORDS);
    localparam int SC    = CW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WREAD, S_WWRITE, S_CREAD, S_CWAIT,
        S_PROBE, S_PWAIT, S_MATH, S_OUT
    } state_t;

    logic [31:0] mem [WORDS];
    logic [31:0] rdata_reg;

    logic [10:0] width_reg, height_reg;
    logic [6:0]  radius_reg;

    state_t          st_reg;
    sdf_in_t         item_reg;
    logic [AW-1:0]   clr_reg;
    logic            cv_reg;
    logic [D2W-1:0]  best_reg;
    logic [RW-1:0]   r_reg;
    logic [1:0]      side_reg;
    logic signed [RW+1:0] k_reg;
    sdf_out_t        res_reg;
    logic            ovalid_reg;
    logic [RW-1:0]   reff;

    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    logic [31:0]     mem_wdata;

    logic [10:0]     weff, heff;
    logic signed [SC:0] px, py, dx, dy;
    logic signed [RW+1:0] rpos, rneg;
    logic            in_map;
    logic [D2W-1:0]  nd2;
    logic            m_start, m_done;
    logic [7:0]      m_value;
    logic [4:0]      bsel;

    assign weff = (width_reg == 0) ? 11'd1 : (width_reg > 11'(MAP_SIDE)) ? 11'(MAP_SIDE)
                  : width_reg;
    assign heff = (height_reg == 0) ? 11'd1 : (height_reg > 11'(MAP_SIDE)) ? 11'(MAP_SIDE)
                  : height_reg;
    assign reff = (radius_reg == 0) ? RW'(1) : (radius_reg > 7'(RADIUS_LIMIT))
                  ? RW'(RADIUS_LIMIT) : RW'(radius_reg);

    assign rpos = $signed((RW+2)'(r_reg));
    assign rneg = -rpos;

    // Offset of the current probe on the ring.
    always_comb
    begin
        unique case (side_reg)
            2'd0: begin dx = (SC+1)'(k_reg); dy = -(SC+1)'(r_reg); end
            2'd1: begin dx = (SC+1)'(k_reg); dy = (SC+1)'(r_reg); end
            2'd2: begin dx = -(SC+1)'(r_reg); dy = (SC+1)'(k_reg); end
            default: begin dx = (SC+1)'(r_reg); dy = (SC+1)'(k_reg); end
        endcase
    end

    assign px     = (SC+1)'(item_reg.col) + dx;
    assign py     = (SC+1)'(item_reg.row) + dy;
    assign in_map = !px[SC] && !py[SC] && (px < (SC+1)'(weff)) && (py < (SC+1)'(heff));
    assign nd2    = D2W'(r_reg) * D2W'(r_reg) + D2W'(k_reg) * D2W'(k_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_wdata = rdata_reg;
        mem_addr  = {item_reg.row, item_reg.col[CW-1:WB]};
        bsel      = item_reg.col[WB-1:0];
        if (st_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            mem_addr  = clr_reg;
        end
        else if (st_reg == S_WWRITE)
        begin
            mem_we          = 1'b1;
            mem_wdata[bsel] = item_reg.pixel_bit;
        end
        else if (st_reg == S_PROBE)
        begin
            mem_addr = {py[CW-1:0], px[CW-1:WB]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            radius_reg <= 7'd32;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                REG_RADIUS: radius_reg <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_RADIUS: prdata = 32'(radius_reg);
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // The probe whose read returned last cycle sits one step behind.
    logic           pend_reg, pin_reg;
    logic [4:0]     pbit_reg;
    logic [D2W-1:0] pd2_reg;
    logic [D2W-1:0] best_now;
    logic           last_probe;
    logic           ring_end;

    assign best_now = (pend_reg && pin_reg && (rdata_reg[pbit_reg] != cv_reg)
                       && (pd2_reg < best_reg)) ? pd2_reg : best_reg;
    assign last_probe = (side_reg == 2'd3) && (k_reg == rpos - (RW+2)'(1));
    assign ring_end   = (r_reg == reff) || (D2W'((r_reg + 1) * (r_reg + 1)) >= best_now);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
            pend_reg <= 1'b0;
            unique case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (&clr_reg)
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_ch.valid && (!ovalid_reg || out_ch.ready))
                    begin
                        item_reg <= in_ch.payload;
                        if (in_ch.payload.op == OP_WRITE)
                        begin
                            st_reg <= S_WREAD;
                        end
                        else if (11'(in_ch.payload.col) >= weff
                                 || 11'(in_ch.payload.row) >= heff)
                        begin
                            res_reg    <= '{sdf_value: 8'd0, nearest_sq_distance: 13'd0,
                                            bad_point: 1'b1};
                            ovalid_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= S_CREAD;
                        end
                    end
                end
                S_WREAD:  st_reg <= S_WWRITE;
                S_WWRITE: st_reg <= S_IDLE;
                S_CREAD:  st_reg <= S_CWAIT;
                S_CWAIT:
                begin
                    cv_reg   <= rdata_reg[item_reg.col[WB-1:0]];
                    best_reg <= D2W'(reff) * D2W'(reff) + D2W'(1);
                    r_reg    <= RW'(1);
                    side_reg <= 2'd0;
                    k_reg    <= -(RW+2)'(1);
                    st_reg   <= S_PROBE;
                end
                S_PROBE:
                begin
                    best_reg <= best_now;
                    pend_reg <= 1'b1;
                    pin_reg  <= in_map;
                    pbit_reg <= px[WB-1:0];
                    pd2_reg  <= nd2;
                    if (last_probe)
                    begin
                        st_reg <= S_PWAIT;
                    end
                    else if (side_reg < 2'd2 && k_reg == rpos)
                    begin
                        side_reg <= side_reg + 2'd1;
                        k_reg    <= (side_reg == 2'd0) ? rneg : rneg + (RW+2)'(1);
                    end
                    else if (side_reg >= 2'd2 && k_reg == rpos - (RW+2)'(1))
                    begin
                        side_reg <= side_reg + 2'd1;
                        k_reg    <= rneg + (RW+2)'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + (RW+2)'(1);
                    end
                end
                S_PWAIT:
                begin
                    best_reg <= best_now;
                    if (ring_end)
                    begin
                        st_reg <= S_MATH;
                    end
                    else
                    begin
                        r_reg    <= r_reg + 1'b1;
                        side_reg <= 2'd0;
                        k_reg    <= rneg - (RW+2)'(1);
                        st_reg   <= S_PROBE;
                    end
                end
                S_MATH:
                begin
                    if (m_done)
                    begin
                        res_reg    <= '{sdf_value: m_value,
                                        nearest_sq_distance: 13'(best_reg),
                                        bad_point: 1'b0};
                        ovalid_reg <= 1'b1;
                        st_reg     <= S_OUT;
                    end
                end
                S_OUT: st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    logic math_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            math_go_reg <= 1'b0;
        end
        else
        begin
            math_go_reg <= (st_reg == S_PWAIT) && ring_end;
        end
    end
    assign m_start = math_go_reg;

    sdf_math u_math (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (m_start),
        .d2     (best_reg),
        .radius (reff),
        .centre (cv_reg),
        .done   (m_done),
        .value  (m_value)
    );

    assign in_ch.ready    = (st_reg == S_IDLE) && (!ovalid_reg || out_ch.ready);
    assign out_ch.valid   = ovalid_reg;
    assign out_ch.payload = res_reg;

    `SDF_ASSERT_IMP(a_no_take_clear, clk, rst_n, st_reg == S_CLEAR, !in_ch.ready,
        "item taken during clearing pass")
    `SDF_ASSERT_NEXT(a_hold_out, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(out_ch.payload), "result item dropped")
    `SDF_ASSERT_IMP(a_best_cap, clk, rst_n, st_reg == S_MATH,
        best_reg <= D2W'(reff) * D2W'(reff) + D2W'(1), "distance beyond cap")
    `SDF_ASSERT_NEXT(a_bad_out, clk, rst_n,
        in_ch.valid && in_ch.ready && in_ch.payload.op == OP_QUERY
        && 11'(in_ch.payload.col) >= weff, out_ch.valid && out_ch.payload.bad_point,
        "outside query not flagged")

endmodule

// ----- hw/rtl/sdf_math.sv -----
// Turns a squared distance into the scaled value: square root one bit per
// cycle, then a multiply by 255 and a restoring divide by 2R, one bit a cycle.
module sdf_math
    import sdf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [D2W-1:0] d2,
    input  logic [RW-1:0]  radius,
    input  logic           centre,
    output logic           done,
    output logic [7:0]     value
);

    typedef enum logic [1:0] {M_IDLE, M_SQRT, M_DIV, M_OUT} mstate_t;

    localparam int RB  = 2 * SW + 2;
    localparam int NB  = SW + 8;
    localparam int DVW = RW + 1;

    mstate_t         st_reg;
    logic [RB-1:0]   n_reg, res_reg, bit_reg;
    logic [NB-1:0]   q_reg, num_reg;
    logic [DVW:0]    rem_reg;
    logic [DVW-1:0]  div_reg;
    logic [5:0]      cnt_reg;
    logic            cv_reg, done_reg;
    logic [7:0]      value_reg;

    logic [RB-1:0]   sum;
    logic [DVW:0]    rsh;
    logic [31:0]     t, v;

    assign sum = res_reg + bit_reg;
    assign rsh = {rem_reg[DVW-1:0], num_reg[NB-1]};
    assign t   = 32'(q_reg);

    always_comb
    begin
        if (cv_reg)
        begin
            v = (MID_Q + t > TOP_Q) ? TOP_Q : MID_Q + t;
        end
        else
        begin
            v = (t >= MID_Q) ? 32'd0 : MID_Q - t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= M_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        n_reg   <= RB'(d2) << 32;
                        res_reg <= '0;
                        bit_reg <= RB'(1) << (RB - 2);
                        div_reg <= DVW'({radius, 1'b0});
                        cv_reg  <= centre;
                        st_reg  <= M_SQRT;
                    end
                end
                M_SQRT:
                begin
                    if (n_reg >= sum)
                    begin
                        n_reg   <= n_reg - sum;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        st_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        num_reg <= NB'(res_reg[SW-1:0]) * NB'(255);
                        rem_reg <= '0;
                        q_reg   <= '0;
                    end
                    else
                    begin
                        num_reg <= num_reg << 1;
                        if (rsh >= {1'b0, div_reg})
                        begin
                            rem_reg <= rsh - {1'b0, div_reg};
                            q_reg   <= {q_reg[NB-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rsh;
                            q_reg   <= {q_reg[NB-2:0], 1'b0};
                        end
                    end
                    if (cnt_reg == 6'(NB))
                    begin
                        st_reg <= M_OUT;
                    end
                end
                M_OUT:
                begin
                    value_reg <= 8'((v + HALF_Q) >> 16);
                    done_reg  <= 1'b1;
                    st_reg    <= M_IDLE;
                end
                default: st_reg <= M_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (st_reg == M_DIV)
        begin
            cnt_reg <= cnt_reg + 6'd1;
        end
        else
        begin
            cnt_reg <= '0;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule
